// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/fbrd_pkg.sv -----
`timescale 1ns / 1ps
package fbrd_pkg;

    // Field widths fixed by the request and write formats.
    localparam int X_W     = 10;
    localparam int ROW_W   = 9;
    localparam int ADDR_W  = 13;
    localparam int CNT_W   = 5;
    localparam int WORD_W  = 5;
    localparam int WPR_W   = 7;
    localparam int ROWCMP_W = 11;

    // Longest span, in word writes.
    localparam int MAX_WRITES = 20;

    // Descriptor queue between the front and back parts.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_PIXEL  = 2'd0,
        REQ_BITMAP = 2'd1,
        REQ_SET    = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req_type;

    // Bitmap row width codes; any other code means thirty-two bits.
    localparam logic [1:0] PSZ_8  = 2'd0;
    localparam logic [1:0] PSZ_16 = 2'd1;

    // One drawing request.
    typedef struct packed {
        t_req_type          req_type;
        logic [X_W-1:0]     x_start;
        logic [X_W-1:0]     x_end;
        logic [ROW_W-1:0]   row;
        logic [31:0]        pattern;
        logic [1:0]         pattern_size;
    } t_req;

    // One masked word write.
    typedef struct packed {
        logic [ADDR_W-1:0]  word_addr;
        logic [31:0]        and_mask;
        logic [31:0]        set_bits;
        logic               last;
    } t_result;

    // Classified request: a run of cnt+1 writes starting at addr.
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [CNT_W-1:0]   cnt;
        logic [31:0]        m_first;
        logic [31:0]        m_last;
        logic               clr;
    } t_desc;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- hdl/fbrd_front.sv -----
`timescale 1ns / 1ps
module fbrd_front
    import fbrd_pkg::*;
#(
    parameter int WORDS_PER_ROW = 20,
    parameter int ROWS = 400
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_req      i_req,
    output logic      o_busy,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_desc     o_desc
);

    localparam int COLS_USED = (WORDS_PER_ROW < MAX_WRITES) ? WORDS_PER_ROW : MAX_WRITES;
    localparam logic [X_W-1:0] X_LIMIT = X_W'(COLS_USED * 32 - 1);
    localparam logic [WPR_W-1:0] WPR_V = WPR_W'(WORDS_PER_ROW);
    localparam logic [ROWCMP_W-1:0] ROWS_V = ROWCMP_W'(ROWS);

    logic       r_in_valid;
    logic       n_in_valid;
    t_req       r_in;
    logic       accept;
    logic       consume;

    logic [X_W-1:0]          xa;
    logic [X_W-1:0]          xb;
    logic [X_W-1:0]          lo_x;
    logic [X_W-1:0]          hi_x;
    logic                    row_ok;
    logic [ROW_W+WPR_W-1:0]  base;
    logic [WORD_W-1:0]       word;
    logic [63:0]             pat_left;
    logic [63:0]             pat_shift;
    logic [5:0]              pat_w;
    logic                    spill;
    t_desc                   desc;

    // Input register: one transaction held until the queue takes it.
    assign accept  = i_start && !o_busy;
    assign consume = r_in_valid && !i_q_status.full;
    assign o_busy  = r_in_valid && i_q_status.full;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (consume) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_req;
        end
    end

    // Saturate columns, order span ends, check the row range and find the row base address.
    always_comb begin
        xa     = (r_in.x_start > X_LIMIT) ? X_LIMIT : r_in.x_start;
        xb     = (r_in.x_end > X_LIMIT) ? X_LIMIT : r_in.x_end;
        lo_x   = (xa < xb) ? xa : xb;
        hi_x   = (xa < xb) ? xb : xa;
        row_ok = ROWCMP_W'(r_in.row) < ROWS_V;
        base   = (ROW_W+WPR_W)'(r_in.row) * (ROW_W+WPR_W)'(WPR_V);
    end

    // Left-align the bitmap row in a two-word window, then shift it to its column.
    always_comb begin
        case (r_in.pattern_size)
            PSZ_8: begin
                pat_left = {r_in.pattern[7:0], 56'd0};
                pat_w    = 6'd8;
            end
            PSZ_16: begin
                pat_left = {r_in.pattern[15:0], 48'd0};
                pat_w    = 6'd16;
            end
            default: begin
                pat_left = {r_in.pattern, 32'd0};
                pat_w    = 6'd32;
            end
        endcase
        pat_shift = pat_left >> xa[4:0];
        spill     = (7'(xa[4:0]) + 7'(pat_w)) > 7'd32;
    end

    // Build the write-run descriptor for each request kind.
    always_comb begin
        desc.clr     = 1'b0;
        desc.cnt     = '0;
        desc.m_first = ALL_ONES;
        desc.m_last  = ALL_ONES;
        word         = xa[X_W-1:5];
        case (r_in.req_type)
            REQ_PIXEL: begin
                desc.m_first = 32'h8000_0000 >> xa[4:0];
            end
            REQ_BITMAP: begin
                desc.m_first = pat_shift[63:32];
                if (spill) begin
                    desc.cnt    = CNT_W'(1);
                    desc.m_last = pat_shift[31:0];
                end
            end
            REQ_SET, REQ_CLEAR: begin
                word         = lo_x[X_W-1:5];
                desc.cnt     = CNT_W'(hi_x[X_W-1:5] - lo_x[X_W-1:5]);
                desc.m_first = ALL_ONES >> lo_x[4:0];
                desc.m_last  = ALL_ONES << (~hi_x[4:0]);
                desc.clr     = (r_in.req_type == REQ_CLEAR);
            end
            default: begin
                desc.cnt = '0;
            end
        endcase
        desc.addr = base[ADDR_W-1:0] + ADDR_W'(word);
    end

    // Rows off the screen are dropped without a write.
    assign o_push = consume && row_ok;
    assign o_desc = desc;

endmodule

// ----- hdl/fbrd_queue.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fbrd_queue
    import fbrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_desc     i_desc,
    input  logic      i_pop,
    output t_desc     o_desc,
    output t_q_status o_status
);

    t_desc             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wptr;
    logic [Q_AW-1:0]   r_rptr;
    logic [Q_CW-1:0]   r_count;
    logic [Q_AW-1:0]   n_wptr;
    logic [Q_AW-1:0]   n_rptr;
    logic [Q_CW-1:0]   n_count;

    // Pointer and fill-count update.
    always_comb begin
        n_wptr  = i_push ? r_wptr + Q_AW'(1) : r_wptr;
        n_rptr  = i_pop ? r_rptr + Q_AW'(1) : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Descriptor storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    assign o_desc         = r_mem[r_rptr];
    assign o_status.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    // Checks on queue occupancy.
    `ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= Q_CW'(Q_DEPTH), "queue overfilled")
    `ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")
    `ASSERT_NXT(a_push_grows, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + Q_CW'(1), "push lost")

endmodule

// ----- hdl/fbrd_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fbrd_back
    import fbrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_status i_q_status,
    input  t_desc     i_desc,
    output logic      o_pop,
    output logic      o_strobe,
    output t_result   o_result
);

    logic             r_active;
    logic             n_active;
    t_desc            r_desc;
    logic [CNT_W-1:0] r_k;
    logic [CNT_W-1:0] n_k;
    logic             r_strobe;
    t_result          r_result;
    t_result          n_result;
    logic             at_last;
    logic [31:0]      mask;

    // Take the next descriptor when idle or on the final write of the current one.
    assign at_last = (r_k == r_desc.cnt);
    assign o_pop   = !i_q_status.empty && (!r_active || at_last);

    always_comb begin
        n_active = r_active;
        n_k      = r_k + CNT_W'(1);
        if (o_pop) begin
            n_active = 1'b1;
            n_k      = '0;
        end else if (r_active && at_last) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_k      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_active <= n_active;
            r_k      <= n_k;
            r_strobe <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_desc;
        end
    end

    // Edge masks on the first and final words, full words between.
    always_comb begin
        mask = ((r_k == '0) ? r_desc.m_first : ALL_ONES) & (at_last ? r_desc.m_last : ALL_ONES);
        n_result.word_addr = r_desc.addr + ADDR_W'(r_k);
        n_result.last      = at_last;
        if (r_desc.clr) begin
            n_result.and_mask = ~mask;
            n_result.set_bits = '0;
        end else begin
            n_result.and_mask = ALL_ONES;
            n_result.set_bits = mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // A run of writes is never broken up, the counter stays within the run, and no descriptor is replaced early.
    `ASSERT_NXT(a_run_contig, i_clk, i_rst_n, o_strobe && !o_result.last, o_strobe, "write run broken")
    `ASSERT_IMP(a_k_bound, i_clk, i_rst_n, r_active, r_k <= r_desc.cnt, "write counter overrun")
    `ASSERT_IMP(a_pop_ok, i_clk, i_rst_n, o_pop, !r_active || at_last, "descriptor replaced early")

endmodule

// ----- hdl/framebuffer_row_draw_engine_unit.sv -----
`timescale 1ns / 1ps
// Row draw engine for a 1-bit-per-pixel framebuffer of 32-bit words.
// A request enters when start is high and busy is low; i_req carries the
// request kind, columns, row, bitmap pattern and pattern width.
// Each request becomes a run of masked word writes, new = (old & and_mask) | set_bits,
// presented on o_result for one cycle each and marked by o_strobe; the last
// write of a run has o_result.last set. Rows at or past ROWS give no writes.
// The receiver cannot stall: every strobe cycle is a taken write.
// When idle, a request's first write follows its accept through the input register,
// the queue and the descriptor and result registers. The write stage issues one word
// per cycle; a request makes one write (pixel), one or two (bitmap row) or up to 20
// (span), and the runs of queued requests follow each other with no gap. While the
// queue has room, the front part classifies one request per cycle into a two-entry
// queue; busy rises only when its input register holds a request and the queue is
// full. Reset (synchronous, active low) empties the queue and the write stage.
module framebuffer_row_draw_engine_unit
    import fbrd_pkg::*;
#(
    parameter int WORDS_PER_ROW = 20,
    parameter int ROWS = 400
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_req    i_req,
    output logic    o_strobe,
    output t_result o_result
);

    t_q_status q_status;
    logic      push;
    logic      pop;
    t_desc     push_desc;
    t_desc     head_desc;

    // Request classification.
    fbrd_front #(
        .WORDS_PER_ROW (WORDS_PER_ROW),
        .ROWS          (ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (i_req),
        .o_busy     (busy),
        .i_q_status (q_status),
        .o_push     (push),
        .o_desc     (push_desc)
    );

    // Descriptor queue.
    fbrd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_desc   (push_desc),
        .i_pop    (pop),
        .o_desc   (head_desc),
        .o_status (q_status)
    );

    // Word write sequencer.
    fbrd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_desc     (head_desc),
        .o_pop      (pop),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

// ----- verif/framebuffer_row_draw_engine_unit_test.sv -----
`timescale 1ns / 1ps
module framebuffer_row_draw_engine_unit_test;
    import fbrd_pkg::*;

    localparam int SCREEN_WPR = 20;
    localparam int SCREEN_ROWS = 400;
    localparam int RANDOM_ITEMS = 500;
    localparam int BLOCK_ITEMS = 50;
    localparam int MAX_GAP = 17;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT = 2000;

    // Expected masked word writes, kept in issue order and checked one by one.
    class write_tracker;
        localparam int COLS_USED = (SCREEN_WPR < MAX_WRITES) ? SCREEN_WPR : MAX_WRITES;
        localparam int X_LIMIT = COLS_USED * 32 - 1;
        localparam int PRINT_LIMIT = 40;

        t_result pending_writes[$];
        int error_count;
        int writes_checked;
        int off_screen_count;
        int spill_count;

        function new();
            error_count = 0;
            writes_checked = 0;
            off_screen_count = 0;
            spill_count = 0;
        endfunction

        // Columns past the last usable pixel stick at that pixel.
        function logic [X_W-1:0] clamp_col(logic [X_W-1:0] x);
            return (x > X_LIMIT) ? X_W'(X_LIMIT) : x;
        endfunction

        function void push_write(logic [ADDR_W-1:0] addr, logic [31:0] and_mask,
                                 logic [31:0] set_bits, logic last);
            t_result w;
            w.word_addr = addr;
            w.and_mask = and_mask;
            w.set_bits = set_bits;
            w.last = last;
            pending_writes.push_back(w);
        endfunction

        // Turns one accepted request into the word writes it should cause.
        function void expand_request(t_req r);
            logic [X_W-1:0] xa;
            logic [X_W-1:0] xb;
            logic [X_W-1:0] lo_x;
            logic [X_W-1:0] hi_x;
            logic [ADDR_W-1:0] base;
            logic [ADDR_W-1:0] addr;
            logic [31:0] bits;
            logic [31:0] m;
            logic [63:0] wide;
            int width;
            int off;
            int first_w;
            int last_w;
            xa = clamp_col(r.x_start);
            xb = clamp_col(r.x_end);
            if (int'(r.row) >= SCREEN_ROWS) begin
                off_screen_count++;
                return;
            end
            base = ADDR_W'(int'(r.row) * SCREEN_WPR);
            addr = base + ADDR_W'(xa[X_W-1:5]);
            case (r.req_type)
                REQ_PIXEL: begin
                    push_write(addr, ALL_ONES, 32'h8000_0000 >> xa[4:0], 1'b1);
                end
                REQ_BITMAP: begin
                    width = (r.pattern_size == PSZ_8) ? 8 : (r.pattern_size == PSZ_16) ? 16 : 32;
                    off = int'(xa[4:0]);
                    bits = (width == 32) ? r.pattern : r.pattern & ((32'd1 << width) - 32'd1);
                    wide = {32'd0, bits} << (64 - width - off);
                    if (off + width > 32) begin
                        // The row crosses a word boundary and spills into the next word.
                        spill_count++;
                        push_write(addr, ALL_ONES, wide[63:32], 1'b0);
                        push_write(addr + 1'b1, ALL_ONES, wide[31:0], 1'b1);
                    end else begin
                        push_write(addr, ALL_ONES, wide[63:32], 1'b1);
                    end
                end
                default: begin
                    // Span ends are inclusive and may come in either order.
                    lo_x = (xa < xb) ? xa : xb;
                    hi_x = (xa < xb) ? xb : xa;
                    first_w = int'(lo_x[X_W-1:5]);
                    last_w = int'(hi_x[X_W-1:5]);
                    for (int c = first_w; c <= last_w; c++) begin
                        m = ALL_ONES;
                        if (c == first_w) m &= ALL_ONES >> lo_x[4:0];
                        if (c == last_w) m &= ALL_ONES << (31 - int'(hi_x[4:0]));
                        if (r.req_type == REQ_CLEAR) begin
                            push_write(base + ADDR_W'(c), ~m, 32'd0, c == last_w);
                        end else begin
                            push_write(base + ADDR_W'(c), ALL_ONES, m, c == last_w);
                        end
                    end
                end
            endcase
        endfunction

        // Prints are capped so that a broken block does not flood the log.
        task report_error(string msg);
            error_count++;
            if (error_count <= PRINT_LIMIT) begin
                $display("ERROR: %s", msg);
            end
        endtask

        task check_write(t_result got);
            t_result exp;
            if (pending_writes.size() == 0) begin
                report_error($sformatf("unexpected write: addr %0d and %h set %h last %b",
                                       got.word_addr, got.and_mask, got.set_bits, got.last));
                return;
            end
            exp = pending_writes.pop_front();
            writes_checked++;
            if (got.word_addr !== exp.word_addr || got.and_mask !== exp.and_mask ||
                got.set_bits !== exp.set_bits || got.last !== exp.last) begin
                report_error($sformatf({"write %0d: got addr %0d and %h set %h last %b, ",
                                        "expected addr %0d and %h set %h last %b"},
                                       writes_checked, got.word_addr, got.and_mask,
                                       got.set_bits, got.last, exp.word_addr,
                                       exp.and_mask, exp.set_bits, exp.last));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_strobe;
    t_result o_result;

    write_tracker board = new();
    int req_counts[4] = '{0, 0, 0, 0};
    int idle_cycles = 0;

    framebuffer_row_draw_engine_unit #(
        .WORDS_PER_ROW(SCREEN_WPR),
        .ROWS(SCREEN_ROWS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Check writes first, then record any request taken on the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                board.check_write(o_result);
            end
            if (start && !busy) begin
                board.expand_request(i_req);
                req_counts[int'(i_req.req_type)]++;
            end
        end
    end

    // Ends the run when neither a request nor a write moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (start && !busy)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d writes outstanding",
                     STALL_LIMIT, board.pending_writes.size());
            $display("framebuffer_row_draw_engine_unit: mismatch");
            $finish;
        end
    end

    function automatic t_req make_req(t_req_type kind, int xs, int xe, int rw,
                                      logic [31:0] pat, logic [1:0] psz);
        t_req r;
        r.req_type = kind;
        r.x_start = X_W'(xs);
        r.x_end = X_W'(xe);
        r.row = ROW_W'(rw);
        r.pattern = pat;
        r.pattern_size = psz;
        return r;
    endfunction

    // Mostly on-screen requests, with some rows past the bottom and columns past the edge.
    function automatic t_req random_request();
        t_req r;
        r.req_type = t_req_type'($urandom_range(3, 0));
        r.x_start = ($urandom_range(99, 0) < 85) ? X_W'($urandom_range(639, 0))
                                                 : X_W'($urandom_range(1023, 0));
        if ($urandom_range(99, 0) < 30) begin
            r.x_end = r.x_start + X_W'($urandom_range(40, 0));
        end else begin
            r.x_end = ($urandom_range(99, 0) < 85) ? X_W'($urandom_range(639, 0))
                                                   : X_W'($urandom_range(1023, 0));
        end
        r.row = ($urandom_range(99, 0) < 92) ? ROW_W'($urandom_range(399, 0))
                                             : ROW_W'($urandom_range(511, 400));
        r.pattern = $urandom();
        r.pattern_size = 2'($urandom_range(3, 0));
        return r;
    endfunction

    // Presents one request and holds it until it is taken, then leaves start low for the gap given.
    task automatic send_request(input t_req r, input int gap);
        @(negedge i_clk);
        i_req <= r;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_for_writes();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.pending_writes.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_req directed[$];
        int gap;
        bit burst;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: edges of the screen, word boundaries, widths and span order.
        directed.push_back(make_req(REQ_PIXEL, 0, 0, 0, 32'h0, 2'd0));
        directed.push_back(make_req(REQ_PIXEL, 639, 0, 399, 32'h0, 2'd0));
        directed.push_back(make_req(REQ_PIXEL, 1023, 1023, 5, ALL_ONES, 2'd3));
        directed.push_back(make_req(REQ_PIXEL, 31, 0, 1, 32'h0, 2'd0));
        directed.push_back(make_req(REQ_BITMAP, 0, 0, 2, 32'hFFFF_FFA5, PSZ_8));
        directed.push_back(make_req(REQ_BITMAP, 24, 0, 3, 32'h0000_00C3, PSZ_8));
        directed.push_back(make_req(REQ_BITMAP, 25, 0, 4, 32'h0000_00FF, PSZ_8));
        directed.push_back(make_req(REQ_BITMAP, 16, 0, 6, 32'hABCD_8001, PSZ_16));
        directed.push_back(make_req(REQ_BITMAP, 17, 0, 7, 32'h0000_FFFF, PSZ_16));
        directed.push_back(make_req(REQ_BITMAP, 32, 0, 8, 32'h8000_0001, 2'd2));
        directed.push_back(make_req(REQ_BITMAP, 33, 0, 9, ALL_ONES, 2'd2));
        directed.push_back(make_req(REQ_BITMAP, 639, 0, 399, ALL_ONES, 2'd3));
        directed.push_back(make_req(REQ_BITMAP, 1023, 0, 10, 32'h1234_5678, 2'd2));
        directed.push_back(make_req(REQ_SET, 0, 639, 0, 32'h0, 2'd0));
        directed.push_back(make_req(REQ_SET, 100, 40, 20, 32'h0, 2'd0));
        directed.push_back(make_req(REQ_SET, 77, 77, 21, 32'h0, 2'd0));
        directed.push_back(make_req(REQ_CLEAR, 0, 639, 399, 32'h0, 2'd0));
        directed.push_back(make_req(REQ_CLEAR, 5, 10, 22, 32'h0, 2'd0));
        directed.push_back(make_req(REQ_CLEAR, 1023, 0, 23, 32'h0, 2'd0));
        directed.push_back(make_req(REQ_SET, 600, 1023, 24, 32'h0, 2'd0));
        directed.push_back(make_req(REQ_PIXEL, 10, 0, 400, 32'h0, 2'd0));
        directed.push_back(make_req(REQ_SET, 0, 639, 511, 32'h0, 2'd0));
        directed.push_back(make_req(REQ_CLEAR, 31, 32, 25, 32'h0, 2'd0));
        directed.push_back(make_req(REQ_PIXEL, 512, 1023, 256, ALL_ONES, 2'd3));
        foreach (directed[i]) begin
            send_request(directed[i], $urandom_range(MAX_GAP, 0));
        end
        wait_for_writes();

        // Random requests in blocks; some blocks run back to back with no idle cycles.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % BLOCK_ITEMS == 0) begin
                burst = ($urandom_range(2, 0) == 0);
            end
            if (i == RANDOM_ITEMS / 2) begin
                wait_for_writes();
            end
            gap = burst ? 0 : $urandom_range(MAX_GAP, 0);
            send_request(random_request(), gap);
        end

        wait_for_writes();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d pixel, %0d bitmap, %0d set-span and %0d clear-span requests;",
                 req_counts[0], req_counts[1], req_counts[2], req_counts[3]);
        $display("%0d word writes checked, %0d bitmap spills, %0d rows past the screen.",
                 board.writes_checked, board.spill_count, board.off_screen_count);
        if (board.error_count == 0) begin
            $display("framebuffer_row_draw_engine_unit: match");
        end else begin
            $display("framebuffer_row_draw_engine_unit: mismatch");
        end
        $finish;
    end

endmodule
